/* rtl/core/frx_pkg.sv */
// frx_pkg: shared types and constants of the xor checked frame receiver
// used by the channel interfaces and by the top level, no dependencies
`default_nettype none

package frx_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_GAP_LIMIT     = 2'd2;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  HEADER_FIRST_RST  = 8'hCD;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'hDC;
    localparam logic [15:0] GAP_LIMIT_RST     = 16'd97;

    // default width of the inter-byte gap counter
    localparam int GAP_COUNTER_WIDTH_DEF = 16;

    // request kinds on the input channel
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // result kinds on the output channel
    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } kind_t;

    // frame end status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_CHECK  = 2'd2,
        ST_TIMEOUT    = 2'd3
    } status_t;

    // one result request
    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_address;
        logic [7:0]  frame_command;
        logic [7:0]  frame_length;
        status_t     frame_status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/frx_if.sv */
// frx_if: valid/ready channel interfaces of the frame receiver
// depends on frx_pkg for payload types and widths
`default_nettype none

// input channel: received bytes and timer ticks
interface frx_in_if;
    logic              valid;
    logic              ready;
    frx_pkg::op_t      operation;
    logic [7:0]        rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// output channel: payload bytes and frame end results
interface frx_out_if;
    logic              valid;
    logic              ready;
    frx_pkg::kind_t    result_kind;
    logic [7:0]        payload_byte;
    logic [7:0]        payload_index;
    logic [7:0]        frame_address;
    logic [7:0]        frame_command;
    logic [7:0]        frame_length;
    frx_pkg::status_t  frame_status;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_address, output frame_command, output frame_length,
        output frame_status, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_address, input frame_command, input frame_length,
        input frame_status, output ready
    );
endinterface

// configuration write channel
interface frx_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [frx_pkg::CFG_INDEX_WIDTH-1:0]   index;
    logic [frx_pkg::CFG_DATA_WIDTH-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/xor_checked_frame_receiver_top.sv */
// result: registered, valid in the cycle after the request that causes it is accepted
// throughput: one request per cycle; the single result register is refilled in the
//   cycle it is taken, so ready drops only while a result waits on a stalled sink
// reset: configuration returns to header 0xCD 0xDC and gap limit 97, parser idle,
//   no result pending; configuration writes are always taken
// xor_checked_frame_receiver_top: frame parser with xor check and gap timeout
// depends on frx_pkg and the channel interfaces in frx_if.sv
`default_nettype none

module xor_checked_frame_receiver_top #(
    parameter int GAP_COUNTER_WIDTH = frx_pkg::GAP_COUNTER_WIDTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    frx_in_if.sink       in_item,
    frx_out_if.source    out_result,
    frx_cfg_if.sink      cfg
);
    import frx_pkg::*;

    localparam int GW    = GAP_COUNTER_WIDTH;
    localparam int CMP_W = (GW > 16) ? GW : 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_ADDR,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    // configuration registers
    logic [7:0]    header_first_reg;
    logic [7:0]    header_second_reg;
    logic [15:0]   gap_limit_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic          header_match_reg, header_match_next;
    logic [7:0]    running_xor_reg, running_xor_next;
    logic [7:0]    held_address_reg, held_address_next;
    logic [7:0]    held_command_reg, held_command_next;
    logic [7:0]    held_length_reg, held_length_next;
    logic [7:0]    payload_count_reg, payload_count_next;
    logic [GW-1:0] gap_count_reg, gap_count_next;

    // result register
    logic          out_valid_reg;
    result_t       result_reg, result_next;
    logic          emit;

    logic          accept;
    logic [GW-1:0] gap_inc;
    logic [7:0]    count_inc;
    logic [7:0]    b;

    // a result may be replaced in the same cycle it is taken
    assign in_item.ready = !out_valid_reg || out_result.ready;
    assign accept        = in_item.valid && in_item.ready;
    assign cfg.ready     = 1'b1;
    assign b             = in_item.rx_byte;

    assign gap_inc   = (gap_count_reg == {GW{1'b1}}) ? gap_count_reg : gap_count_reg + 1'b1;
    assign count_inc = payload_count_reg + 8'd1;

    // next state and result of the accepted request
    always_comb
    begin
        phase_next         = phase_reg;
        header_match_next  = header_match_reg;
        running_xor_next   = running_xor_reg;
        held_address_next  = held_address_reg;
        held_command_next  = held_command_reg;
        held_length_next   = held_length_reg;
        payload_count_next = payload_count_reg;
        gap_count_next     = gap_count_reg;
        emit               = 1'b0;
        result_next.result_kind   = KIND_FRAME_END;
        result_next.payload_byte  = 8'd0;
        result_next.payload_index = 8'd0;
        result_next.frame_address = held_address_reg;
        result_next.frame_command = held_command_reg;
        result_next.frame_length  = held_length_reg;
        result_next.frame_status  = ST_OK;

        if (in_item.operation == OP_TICK)
        begin
            // ticks count only inside a frame
            if (phase_reg != PH_IDLE)
            begin
                gap_count_next = gap_inc;
                if (CMP_W'(gap_inc) >= CMP_W'(gap_limit_reg))
                begin
                    emit                     = 1'b1;
                    result_next.frame_status = ST_TIMEOUT;
                    phase_next               = PH_IDLE;
                    header_match_next        = 1'b1;
                    gap_count_next           = '0;
                end
            end
        end
        else
        begin
            gap_count_next = '0;
            case (phase_reg)
                PH_IDLE:
                begin
                    running_xor_next   = 8'd0;
                    held_address_next  = 8'd0;
                    held_command_next  = 8'd0;
                    held_length_next   = 8'd0;
                    payload_count_next = 8'd0;
                    header_match_next  = (b == header_first_reg);
                    phase_next         = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (b != header_second_reg)
                    begin
                        header_match_next = 1'b0;
                    end
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    held_address_next = b;
                    running_xor_next  = running_xor_reg ^ b;
                    phase_next        = PH_CMD;
                end
                PH_CMD:
                begin
                    held_command_next = b;
                    running_xor_next  = running_xor_reg ^ b;
                    phase_next        = PH_LEN;
                end
                PH_LEN:
                begin
                    held_length_next = b;
                    running_xor_next = running_xor_reg ^ b;
                    if (!header_match_reg)
                    begin
                        // header judged once address, command and length are in
                        emit                      = 1'b1;
                        result_next.frame_length  = b;
                        result_next.frame_status  = ST_BAD_HEADER;
                        phase_next                = PH_IDLE;
                        header_match_next         = 1'b1;
                    end
                    else
                    begin
                        phase_next = (b == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    running_xor_next          = running_xor_reg ^ b;
                    emit                      = 1'b1;
                    result_next.result_kind   = KIND_PAYLOAD;
                    result_next.payload_byte  = b;
                    result_next.payload_index = payload_count_reg;
                    payload_count_next        = count_inc;
                    if (count_inc >= held_length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                default:
                begin
                    // check byte closes the frame
                    emit                     = 1'b1;
                    result_next.frame_status = (b == running_xor_reg) ? ST_OK : ST_BAD_CHECK;
                    phase_next               = PH_IDLE;
                    header_match_next        = 1'b1;
                end
            endcase
        end
    end

    // state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            gap_limit_reg     <= GAP_LIMIT_RST;
            phase_reg         <= PH_IDLE;
            header_match_reg  <= 1'b1;
            running_xor_reg   <= 8'd0;
            held_address_reg  <= 8'd0;
            held_command_reg  <= 8'd0;
            held_length_reg   <= 8'd0;
            payload_count_reg <= 8'd0;
            gap_count_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_HEADER_FIRST:  header_first_reg  <= cfg.data[7:0];
                    CFG_HEADER_SECOND: header_second_reg <= cfg.data[7:0];
                    CFG_GAP_LIMIT:     gap_limit_reg     <= cfg.data;
                    default:           ;
                endcase
            end
            if (accept)
            begin
                phase_reg         <= phase_next;
                header_match_reg  <= header_match_next;
                running_xor_reg   <= running_xor_next;
                held_address_reg  <= held_address_next;
                held_command_reg  <= held_command_next;
                held_length_reg   <= held_length_next;
                payload_count_reg <= payload_count_next;
                gap_count_reg     <= gap_count_next;
            end
            if (accept)
            begin
                out_valid_reg <= emit;
            end
            else if (out_result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload holds while a result waits
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    // result channel drive
    assign out_result.valid         = out_valid_reg;
    assign out_result.result_kind   = result_reg.result_kind;
    assign out_result.payload_byte  = result_reg.payload_byte;
    assign out_result.payload_index = result_reg.payload_index;
    assign out_result.frame_address = result_reg.frame_address;
    assign out_result.frame_command = result_reg.frame_command;
    assign out_result.frame_length  = result_reg.frame_length;
    assign out_result.frame_status  = result_reg.frame_status;

    // an idle parser holds no gap count and an intact header flag
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> (gap_count_reg == '0 && header_match_reg))
        else $error("idle parser with stale gap count or header flag");

    // payload results carry ok status and an index inside the declared length
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.result_kind == KIND_PAYLOAD) |->
        (result_reg.frame_status == ST_OK &&
         result_reg.payload_index < result_reg.frame_length))
        else $error("payload result out of frame bounds");

    // payload phase never runs past the declared length
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> payload_count_reg < held_length_reg)
        else $error("payload count beyond declared length");

    // a request causing a result leaves it pending in the next cycle
    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> out_valid_reg)
        else $error("result lost after request");

endmodule

`default_nettype wire
